### rtl/bl2d_pkg.sv
// Shared types, widths and constants of the batched byte L2 distance block.
package bl2d_pkg;

  // Fixed field widths.
  localparam int unsigned ByteW   = 8;
  localparam int unsigned CfgW    = 4;
  localparam int unsigned SumW    = 28;
  localparam int unsigned SqW     = 16;
  localparam int unsigned OutW    = 31;
  localparam int unsigned IoLanes = 8;

  // Single-precision layout, sign bit dropped.
  localparam int unsigned ExpW    = 8;
  localparam int unsigned FracW   = 23;
  localparam int unsigned PosW    = 5;
  localparam logic [ExpW-1:0] ExpBias = 8'd127;

  // Lane count reported after reset.
  localparam logic [CfgW-1:0] LanesReset = 4'd8;

  typedef logic [ByteW-1:0] byte_t;
  typedef logic [SumW-1:0]  sum_t;
  typedef logic [OutW-1:0]  dist_t;

  // Advance enables for the two conversion registers.
  typedef struct packed {
    logic adv_norm;
    logic adv_out;
  } cvt_ctl_t;

endpackage

### rtl/bl2d_lane.sv
// One distance lane: byte difference, square and saturating accumulation.
module bl2d_lane (
  input  logic           clk_i,
  input  logic           rst_ni,
  input  logic           acc_en_i,
  input  logic           clear_i,
  input  bl2d_pkg::byte_t query_i,
  input  bl2d_pkg::byte_t db_i,
  output bl2d_pkg::sum_t  sum_next_o
);
  import bl2d_pkg::*;

  logic signed [ByteW:0]     diff;
  logic signed [2*ByteW+1:0] prod;
  logic [SqW-1:0]            sq;
  logic [SumW:0]             sum_wide;
  sum_t                      sum_d, sum_q;

  // Signed difference and its square; the square always fits in 16 bits.
  assign diff = $signed({1'b0, query_i}) - $signed({1'b0, db_i});
  assign prod = diff * diff;
  assign sq   = prod[SqW-1:0];

  // Add with saturation at the top of the sum range.
  assign sum_wide   = {1'b0, sum_q} + {{(SumW+1-SqW){1'b0}}, sq};
  assign sum_next_o = sum_wide[SumW] ? {SumW{1'b1}} : sum_wide[SumW-1:0];

  // The last item of a vector restarts the sum.
  always_comb begin
    sum_d = sum_q;
    if (acc_en_i) begin
      sum_d = clear_i ? '0 : sum_next_o;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      sum_q <= '0;
    end else begin
      sum_q <= sum_d;
    end
  end

endmodule

### rtl/bl2d_to_fp.sv
// Two-stage conversion of a lane sum to a rounded single-precision pattern.
module bl2d_to_fp (
  input  logic               clk_i,
  input  bl2d_pkg::cvt_ctl_t ctl_i,
  input  bl2d_pkg::sum_t     sum_i,
  output bl2d_pkg::dist_t    dist_o
);
  import bl2d_pkg::*;

  logic [PosW-1:0]  pos;
  logic             nz;
  sum_t             val_q;
  logic [PosW-1:0]  pos_q;
  logic             nz_q;
  logic [PosW-1:0]  shamt;
  sum_t             norm;
  logic             guard, sticky, rnd;
  logic [FracW+1:0] mant;
  logic             carry;
  logic [ExpW-1:0]  expo;
  dist_t            dist_d, dist_q;

  // Stage one: position of the leading one.
  always_comb begin
    pos = '0;
    nz  = 1'b0;
    for (int i = 0; i < SumW; i++) begin
      if (sum_i[i]) begin
        pos = PosW'(i);
        nz  = 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_norm) begin
      val_q <= sum_i;
      pos_q <= pos;
      nz_q  <= nz;
    end
  end

  // Stage two: normalize, round to nearest even and pack.
  assign shamt  = PosW'(SumW - 1) - pos_q;
  assign norm   = val_q << shamt;
  assign guard  = norm[SumW-FracW-2];
  assign sticky = |norm[SumW-FracW-3:0];
  assign rnd    = guard && (sticky || norm[SumW-FracW-1]);
  assign mant   = {1'b0, norm[SumW-1:SumW-FracW-1]} + {{(FracW+1){1'b0}}, rnd};
  assign carry  = mant[FracW+1];
  assign expo   = ExpBias + {{(ExpW-PosW){1'b0}}, pos_q} + {{(ExpW-1){1'b0}}, carry};

  always_comb begin
    dist_d = '0;
    if (nz_q) begin
      dist_d = {expo, carry ? {FracW{1'b0}} : mant[FracW-1:0]};
    end
  end

  always_ff @(posedge clk_i) begin
    if (ctl_i.adv_out) begin
      dist_q <= dist_d;
    end
  end

  assign dist_o = dist_q;

endmodule

### rtl/batched_uint8_l2_distance.sv
// Top level: lane accumulators, result merge stage and float conversion pipeline.
//
//  Channel  | Handshake                    | Payload
//  ---------+------------------------------+-------------------------------------------
//  in       | in_valid_i / in_ready_o      | query_byte_i, db_byte_0_i..7_i, last_element_i
//  out      | out_valid_o / out_ready_i    | distance_0_o .. distance_7_o
//  cfg      | cfg_we_i (no wait)           | cfg_wdata_i = lanes_in_use
//
//  One item is taken per cycle while in_ready_o is high; each lane does one subtract, square and add.
//  After its last item a result leaves through the merge register, the leading-one
//  search register, then normalize and round into the output register.
//  Reset clears the lane sums, all valid bits and sets lanes_in_use to eight.
//  A stalled output holds its stage; earlier stages keep moving into empty slots.
module batched_uint8_l2_distance #(
  parameter int unsigned LANES = 8
) (
  input  logic                           clk_i,
  input  logic                           rst_ni,
  input  logic                           cfg_we_i,
  input  logic [bl2d_pkg::CfgW-1:0]      cfg_wdata_i,
  input  logic                           in_valid_i,
  output logic                           in_ready_o,
  input  bl2d_pkg::byte_t                query_byte_i,
  input  bl2d_pkg::byte_t                db_byte_0_i,
  input  bl2d_pkg::byte_t                db_byte_1_i,
  input  bl2d_pkg::byte_t                db_byte_2_i,
  input  bl2d_pkg::byte_t                db_byte_3_i,
  input  bl2d_pkg::byte_t                db_byte_4_i,
  input  bl2d_pkg::byte_t                db_byte_5_i,
  input  bl2d_pkg::byte_t                db_byte_6_i,
  input  bl2d_pkg::byte_t                db_byte_7_i,
  input  logic                           last_element_i,
  output logic                           out_valid_o,
  input  logic                           out_ready_i,
  output bl2d_pkg::dist_t                distance_0_o,
  output bl2d_pkg::dist_t                distance_1_o,
  output bl2d_pkg::dist_t                distance_2_o,
  output bl2d_pkg::dist_t                distance_3_o,
  output bl2d_pkg::dist_t                distance_4_o,
  output bl2d_pkg::dist_t                distance_5_o,
  output bl2d_pkg::dist_t                distance_6_o,
  output bl2d_pkg::dist_t                distance_7_o
);
  import bl2d_pkg::*;

  // Lanes that have both an input byte and a sum register.
  localparam int unsigned NumLanes = (LANES < IoLanes) ? LANES : IoLanes;

  logic [CfgW-1:0] lanes_d, lanes_q;
  byte_t           db        [IoLanes];
  dist_t           lane_dist [IoLanes];
  logic            acc, fire_last;
  logic            rdy_merge, rdy_norm, rdy_out;
  logic            v_merge_d, v_merge_q;
  logic            v_norm_d, v_norm_q;
  logic            v_out_d, v_out_q;
  cvt_ctl_t        cvt_ctl;

  assign db[0] = db_byte_0_i;
  assign db[1] = db_byte_1_i;
  assign db[2] = db_byte_2_i;
  assign db[3] = db_byte_3_i;
  assign db[4] = db_byte_4_i;
  assign db[5] = db_byte_5_i;
  assign db[6] = db_byte_6_i;
  assign db[7] = db_byte_7_i;

  // Lane count register.
  assign lanes_d = cfg_we_i ? cfg_wdata_i : lanes_q;

  // Pipeline flow: a stage loads when it is empty or its successor moves.
  assign rdy_out   = !v_out_q || out_ready_i;
  assign rdy_norm  = !v_norm_q || rdy_out;
  assign rdy_merge = !v_merge_q || rdy_norm;
  assign in_ready_o = rdy_merge;
  assign acc        = in_valid_i && rdy_merge;
  assign fire_last  = acc && last_element_i;

  assign v_merge_d = rdy_merge ? fire_last : v_merge_q;
  assign v_norm_d  = rdy_norm ? v_merge_q : v_norm_q;
  assign v_out_d   = rdy_out ? v_norm_q : v_out_q;

  assign cvt_ctl.adv_norm = rdy_norm;
  assign cvt_ctl.adv_out  = rdy_out;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      lanes_q   <= LanesReset;
      v_merge_q <= 1'b0;
      v_norm_q  <= 1'b0;
      v_out_q   <= 1'b0;
    end else begin
      lanes_q   <= lanes_d;
      v_merge_q <= v_merge_d;
      v_norm_q  <= v_norm_d;
      v_out_q   <= v_out_d;
    end
  end

  assign out_valid_o = v_out_q;

  // Per-lane datapath; lanes without storage report zero.
  for (genvar j = 0; j < IoLanes; j++) begin : g_lane
    if (j < NumLanes) begin : g_act
      sum_t sum_next;
      sum_t fin_q;

      bl2d_lane u_lane (
        .clk_i      (clk_i),
        .rst_ni     (rst_ni),
        .acc_en_i   (acc),
        .clear_i    (fire_last),
        .query_i    (query_byte_i),
        .db_i       (db[j]),
        .sum_next_o (sum_next)
      );

      // Merge stage: capture the final sum, masked by the lane count in force.
      always_ff @(posedge clk_i) begin
        if (fire_last) begin
          fin_q <= (CfgW'(j) < lanes_q) ? sum_next : '0;
        end
      end

      bl2d_to_fp u_cvt (
        .clk_i  (clk_i),
        .ctl_i  (cvt_ctl),
        .sum_i  (fin_q),
        .dist_o (lane_dist[j])
      );
    end else begin : g_off
      assign lane_dist[j] = '0;
    end
  end

  assign distance_0_o = lane_dist[0];
  assign distance_1_o = lane_dist[1];
  assign distance_2_o = lane_dist[2];
  assign distance_3_o = lane_dist[3];
  assign distance_4_o = lane_dist[4];
  assign distance_5_o = lane_dist[5];
  assign distance_6_o = lane_dist[6];
  assign distance_7_o = lane_dist[7];

endmodule
